// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top RTL file of the obstacle avoidance block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define UOA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define UOA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UOA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define UOA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/core/uoa_pkg.sv -----
// Types, codes and constants of the ultrasonic obstacle avoidance block.
package uoa_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_FRONT_BLOCK = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SIDE_BLOCK  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CRASH       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PIVOT       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BRIEF_STOP  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD        = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_BACK        = 3'd6;

    localparam logic [6:0]  RANGE_CLAMP_CM      = 7'd100;
    localparam logic [6:0]  FRONT_BLOCK_RESET   = 7'd30;
    localparam logic [6:0]  SIDE_BLOCK_RESET    = 7'd10;
    localparam logic [6:0]  CRASH_RESET         = 7'd10;
    localparam logic [15:0] PIVOT_MS_RESET      = 16'd80;
    localparam logic [15:0] BRIEF_STOP_MS_RESET = 16'd80;
    localparam logic [15:0] HOLD_MS_RESET       = 16'd100;
    localparam logic [15:0] BACK_MS_RESET       = 16'd250;

    localparam logic [2:0] MODE_STOP  = 3'd0;
    localparam logic [2:0] MODE_SCAN  = 3'd1;
    localparam logic [2:0] MODE_PIVOT = 3'd2;
    localparam logic [2:0] MODE_BRIEF = 3'd3;
    localparam logic [2:0] MODE_HOLD  = 3'd4;
    localparam logic [2:0] MODE_BACK  = 3'd5;

    localparam logic [2:0] ACT_FORWARD = 3'd0;
    localparam logic [2:0] ACT_BACK    = 3'd1;
    localparam logic [2:0] ACT_LEFT    = 3'd2;
    localparam logic [2:0] ACT_RIGHT   = 3'd3;
    localparam logic [2:0] ACT_STOP    = 3'd4;

    localparam logic [6:0] SPEED_DRIVE = 7'd50;
    localparam logic [6:0] SPEED_PIVOT = 7'd60;
    localparam logic [6:0] SPEED_STOP  = 7'd0;

    localparam logic DIR_LEFT  = 1'b0;
    localparam logic DIR_RIGHT = 1'b1;

    typedef struct packed {
        logic [7:0]  left_raw_cm;
        logic [7:0]  center_raw_cm;
        logic [7:0]  right_raw_cm;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic       drive_issued;
        logic [2:0] drive_action;
        logic [6:0] speed_percent;
        logic [2:0] mode;
    } out_item_t;

    typedef struct packed {
        logic [6:0]  front_block_cm;
        logic [6:0]  side_block_cm;
        logic [6:0]  crash_cm;
        logic [15:0] pivot_ms;
        logic [15:0] brief_stop_ms;
        logic [15:0] hold_ms;
        logic [15:0] back_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] mark_time;
        logic        pivot_dir;
    } state_t;

    function automatic logic [6:0] clamp_cm(input logic [7:0] raw);
        logic [6:0] v;
        begin
            if ((raw == 8'd0) || (raw > {1'b0, RANGE_CLAMP_CM}))
            begin
                v = RANGE_CLAMP_CM;
            end
            else
            begin
                v = raw[6:0];
            end
            return v;
        end
    endfunction

endpackage

// ----- rtl/core/ultrasonic_obstacle_avoid_fsm.sv -----
// Top level of the ultrasonic obstacle avoidance mode machine.
// Each input transfer on in_item carries three raw distances and the current
// millisecond time. Each accepted item gives exactly one result transfer on
// out_item with the new mode and, when a command is issued, its action and speed.
// The item is registered on acceptance and decided from the input register, and the
// result is registered in the output register, from which it is offered on out_item.
// One item is taken every cycle while out_stall is low; the mode state is updated
// as each item is decided, so consecutive items see each other's effect.
// When out_stall is high with a result waiting, one more item is still taken into
// the input register and in_stall rises only when both registers are full.
// Reset empties both registers, sets the mode to stop with the time mark at zero
// and the pivot direction left, and loads the register reset values.
// Configuration registers are written through cfg_wr_en, cfg_index and cfg_data;
// an index beyond the register list is ignored.
`include "assert_macros.svh"

module ultrasonic_obstacle_avoid_fsm
    import uoa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_item,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t      cfg;
    in_item_t  in_item_reg;
    in_item_t  in_item_next;
    logic      in_valid_reg;
    logic      in_valid_next;
    state_t    state_reg;
    state_t    state_next;
    state_t    step_state;
    out_item_t step_result;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      advance;

    uoa_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    uoa_step u_step (
        .item    (in_item_reg),
        .st      (state_reg),
        .cfg     (cfg),
        .result  (step_result),
        .st_next (step_state)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_comb
    begin
        in_valid_next  = in_stall ? in_valid_reg : in_valid;
        in_item_next   = in_stall ? in_item_reg : in_item;
        state_next     = advance ? step_state : state_reg;
        out_item_next  = advance ? step_result : out_item_reg;
        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            state_reg.mode      <= MODE_STOP;
            state_reg.mark_time <= '0;
            state_reg.pivot_dir <= DIR_LEFT;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `UOA_ASSERT_NXT(a_mode_matches_result, clk, rst_n, advance,
        out_item.mode == state_reg.mode, "result mode differs from stored mode")
    `UOA_ASSERT_NXT(a_left_stop_mode, clk, rst_n, advance,
        state_reg.mode != MODE_STOP && state_reg.mode <= MODE_BACK,
        "mode machine in stop or unused code after an item")
    `UOA_ASSERT_IMP(a_idle_fields_zero, clk, rst_n, out_valid && !out_item.drive_issued,
        out_item.drive_action == ACT_FORWARD && out_item.speed_percent == SPEED_STOP,
        "fields not cleared without a command")
    `UOA_ASSERT_IMP(a_speed_fits_action, clk, rst_n, out_valid && out_item.drive_issued,
        (out_item.drive_action == ACT_STOP && out_item.speed_percent == SPEED_STOP)
        || ((out_item.drive_action == ACT_LEFT || out_item.drive_action == ACT_RIGHT)
            && out_item.speed_percent == SPEED_PIVOT)
        || ((out_item.drive_action == ACT_FORWARD || out_item.drive_action == ACT_BACK)
            && out_item.speed_percent == SPEED_DRIVE),
        "speed does not fit the action")
    `UOA_ASSERT_IMP(a_no_item_lost, clk, rst_n, in_stall, in_valid_reg && out_valid_reg,
        "input stalled with a free register")

endmodule

// ----- rtl/core/uoa_cfg.sv -----
// Configuration register file of the obstacle avoidance block.
module uoa_cfg
    import uoa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FRONT_BLOCK: cfg_next.front_block_cm = cfg_data[6:0];
                REG_SIDE_BLOCK:  cfg_next.side_block_cm  = cfg_data[6:0];
                REG_CRASH:       cfg_next.crash_cm       = cfg_data[6:0];
                REG_PIVOT:       cfg_next.pivot_ms       = cfg_data;
                REG_BRIEF_STOP:  cfg_next.brief_stop_ms  = cfg_data;
                REG_HOLD:        cfg_next.hold_ms        = cfg_data;
                REG_BACK:        cfg_next.back_ms        = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.front_block_cm <= FRONT_BLOCK_RESET;
            cfg_reg.side_block_cm  <= SIDE_BLOCK_RESET;
            cfg_reg.crash_cm       <= CRASH_RESET;
            cfg_reg.pivot_ms       <= PIVOT_MS_RESET;
            cfg_reg.brief_stop_ms  <= BRIEF_STOP_MS_RESET;
            cfg_reg.hold_ms        <= HOLD_MS_RESET;
            cfg_reg.back_ms        <= BACK_MS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/uoa_step.sv -----
// Decision logic: one item against the current mode state gives a result and the next state.
module uoa_step
    import uoa_pkg::*;
(
    input  in_item_t  item,
    input  state_t    st,
    input  cfg_t      cfg,
    output out_item_t result,
    output state_t    st_next
);

    logic [6:0]  left_cm;
    logic [6:0]  center_cm;
    logic [6:0]  right_cm;
    logic [31:0] elapsed;
    logic        crash;
    logic        left_wall;
    logic        right_wall;
    logic        danger;
    logic        turn_right;
    logic        pivot_done;
    logic        brief_done;
    logic        hold_done;
    logic        back_done;

    always_comb
    begin
        left_cm    = clamp_cm(item.left_raw_cm);
        center_cm  = clamp_cm(item.center_raw_cm);
        right_cm   = clamp_cm(item.right_raw_cm);
        elapsed    = item.now_ms - st.mark_time;
        crash      = center_cm < cfg.crash_cm;
        left_wall  = left_cm < cfg.side_block_cm;
        right_wall = right_cm < cfg.side_block_cm;
        danger     = (center_cm < cfg.front_block_cm) || left_wall || right_wall;
        // With exactly one wall near, turn away from it; otherwise turn toward the farther side.
        turn_right = (left_wall ^ right_wall) ? left_wall : (left_cm <= right_cm);
        pivot_done = elapsed >= {16'd0, cfg.pivot_ms};
        brief_done = elapsed >= {16'd0, cfg.brief_stop_ms};
        hold_done  = elapsed >= {16'd0, cfg.hold_ms};
        back_done  = elapsed >= {16'd0, cfg.back_ms};

        result  = '0;
        st_next = st;

        case (st.mode)
            MODE_SCAN, MODE_HOLD:
            begin
                if (crash)
                begin
                    result.drive_issued  = 1'b1;
                    result.drive_action  = ACT_BACK;
                    result.speed_percent = SPEED_DRIVE;
                    st_next.mark_time    = item.now_ms;
                    st_next.mode         = MODE_BACK;
                end
                else if (danger)
                begin
                    result.drive_issued  = 1'b1;
                    result.drive_action  = turn_right ? ACT_RIGHT : ACT_LEFT;
                    result.speed_percent = SPEED_PIVOT;
                    st_next.pivot_dir    = turn_right ? DIR_RIGHT : DIR_LEFT;
                    st_next.mark_time    = item.now_ms;
                    st_next.mode         = MODE_PIVOT;
                end
                else if (st.mode == MODE_SCAN)
                begin
                    result.drive_issued  = 1'b1;
                    result.drive_action  = ACT_FORWARD;
                    result.speed_percent = SPEED_DRIVE;
                end
                else if (hold_done)
                begin
                    st_next.mode = MODE_SCAN;
                end
            end
            MODE_PIVOT:
            begin
                if (pivot_done)
                begin
                    result.drive_issued = 1'b1;
                    st_next.mark_time   = item.now_ms;
                    if (danger)
                    begin
                        result.drive_action  = turn_right ? ACT_RIGHT : ACT_LEFT;
                        result.speed_percent = SPEED_PIVOT;
                        st_next.pivot_dir    = turn_right ? DIR_RIGHT : DIR_LEFT;
                        st_next.mode         = MODE_PIVOT;
                    end
                    else
                    begin
                        result.drive_action  = ACT_STOP;
                        result.speed_percent = SPEED_STOP;
                        st_next.mode         = MODE_BRIEF;
                    end
                end
            end
            MODE_BRIEF:
            begin
                if (brief_done)
                begin
                    result.drive_issued  = 1'b1;
                    result.drive_action  = ACT_FORWARD;
                    result.speed_percent = SPEED_DRIVE;
                    st_next.mark_time    = item.now_ms;
                    st_next.mode         = MODE_HOLD;
                end
            end
            MODE_BACK:
            begin
                if (back_done)
                begin
                    result.drive_issued  = 1'b1;
                    result.drive_action  = ACT_STOP;
                    result.speed_percent = SPEED_STOP;
                    st_next.mode         = MODE_SCAN;
                end
            end
            default:
            begin
                st_next.mode = MODE_SCAN;
            end
        endcase

        result.mode = st_next.mode;
    end

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the ultrasonic obstacle avoidance mode machine.
module testbench
    import uoa_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [2:0] ACT_NONE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORDER [7] = '{REG_FRONT_BLOCK, REG_SIDE_BLOCK,
        REG_CRASH, REG_PIVOT, REG_BRIEF_STOP, REG_HOLD, REG_BACK};

    typedef struct {
        in_item_t  reading;
        bit        typed;
        out_item_t want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    in_item_t               in_item = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_item;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    cfg_t        regs;
    state_t      ctl;
    out_item_t   pending_drive [$];
    out_item_t   head_drive;
    logic [15:0] reg_plan [7];
    logic [31:0] clock_ms = '0;
    int unsigned span_ms = 40;
    bit          quiet = 1'b0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    int          errors = 0;
    int          readings_sent = 0;
    int          results_seen = 0;
    int          settings_used = 1;

    stim_row_t dir_rows [24] = '{
        '{'{8'd0, 8'd0, 8'd0, 32'd0}, 1'b1, '{1'b0, ACT_NONE, SPEED_STOP, MODE_SCAN}},
        '{'{8'd255, 8'd255, 8'd255, 32'd1}, 1'b1,
            '{1'b1, ACT_FORWARD, SPEED_DRIVE, MODE_SCAN}},
        '{'{8'd100, 8'd101, 8'd1, 32'd2}, 1'b1, '{1'b1, ACT_LEFT, SPEED_PIVOT, MODE_PIVOT}},
        '{'{8'd100, 8'd100, 8'd100, 32'd50}, 1'b0, '0},
        '{'{8'd100, 8'd100, 8'd100, 32'd82}, 1'b0, '0},
        '{'{8'd100, 8'd100, 8'd100, 32'd161}, 1'b0, '0},
        '{'{8'd100, 8'd100, 8'd100, 32'd162}, 1'b0, '0},
        '{'{8'd100, 8'd100, 8'd100, 32'd200}, 1'b0, '0},
        '{'{8'd100, 8'd100, 8'd100, 32'd262}, 1'b0, '0},
        '{'{8'd100, 8'd9, 8'd100, 32'd300}, 1'b1, '{1'b1, ACT_BACK, SPEED_DRIVE, MODE_BACK}},
        '{'{8'd100, 8'd9, 8'd100, 32'd549}, 1'b0, '0},
        '{'{8'd100, 8'd100, 8'd100, 32'd550}, 1'b1, '{1'b1, ACT_STOP, SPEED_STOP, MODE_SCAN}},
        '{'{8'd40, 8'd29, 8'd40, 32'd600}, 1'b0, '0},
        '{'{8'd9, 8'd29, 8'd50, 32'd680}, 1'b0, '0},
        '{'{8'd5, 8'd100, 8'd3, 32'd760}, 1'b0, '0},
        '{'{8'd3, 8'd100, 8'd3, 32'd840}, 1'b0, '0},
        '{'{8'd60, 8'd29, 8'd20, 32'd920}, 1'b0, '0},
        '{'{8'd100, 8'd100, 8'd100, 32'd1000}, 1'b0, '0},
        '{'{8'd100, 8'd100, 8'd100, 32'd1080}, 1'b0, '0},
        '{'{8'd7, 8'd200, 8'd100, 32'd1090}, 1'b0, '0},
        '{'{8'd100, 8'd100, 8'd100, 32'hFFFF_FFF0}, 1'b0, '0},
        '{'{8'd100, 8'd100, 8'd100, 32'h0000_0040}, 1'b0, '0},
        '{'{8'd100, 8'd5, 8'd100, 32'h0000_0041}, 1'b0, '0},
        '{'{8'd100, 8'd100, 8'd100, 32'h0000_013B}, 1'b0, '0}
    };

    ultrasonic_obstacle_avoid_fsm i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [6:0] limit_range(input logic [7:0] raw);
        begin
            if (raw == 8'd0 || raw > 8'd100)
            begin
                return 7'd100;
            end
            return raw[6:0];
        end
    endfunction

    function automatic out_item_t begin_turn(input logic [6:0] l, input logic [6:0] r,
                                             input logic [31:0] now);
        logic      wall_l;
        logic      wall_r;
        out_item_t res;
        begin
            wall_l = l < regs.side_block_cm;
            wall_r = r < regs.side_block_cm;
            if (wall_l && !wall_r)
            begin
                ctl.pivot_dir = DIR_RIGHT;
            end
            else if (wall_r && !wall_l)
            begin
                ctl.pivot_dir = DIR_LEFT;
            end
            else if (wall_l && wall_r)
            begin
                ctl.pivot_dir = (l <= r) ? DIR_RIGHT : DIR_LEFT;
            end
            else
            begin
                ctl.pivot_dir = (r >= l) ? DIR_RIGHT : DIR_LEFT;
            end
            res = '0;
            res.drive_issued = 1'b1;
            res.drive_action = (ctl.pivot_dir == DIR_RIGHT) ? ACT_RIGHT : ACT_LEFT;
            res.speed_percent = SPEED_PIVOT;
            ctl.mark_time = now;
            ctl.mode = MODE_PIVOT;
            return res;
        end
    endfunction

    function automatic out_item_t begin_reverse(input logic [31:0] now);
        out_item_t res;
        begin
            res = '0;
            res.drive_issued = 1'b1;
            res.drive_action = ACT_BACK;
            res.speed_percent = SPEED_DRIVE;
            ctl.mark_time = now;
            ctl.mode = MODE_BACK;
            return res;
        end
    endfunction

    function automatic out_item_t drive_cmd(input logic [2:0] act, input logic [6:0] speed);
        out_item_t res;
        begin
            res = '0;
            res.drive_issued = 1'b1;
            res.drive_action = act;
            res.speed_percent = speed;
            return res;
        end
    endfunction

    function automatic out_item_t predict_drive(input in_item_t it);
        logic [6:0]  l;
        logic [6:0]  c;
        logic [6:0]  r;
        logic [31:0] waited;
        logic        hazard;
        out_item_t   res;
        begin
            l = limit_range(it.left_raw_cm);
            c = limit_range(it.center_raw_cm);
            r = limit_range(it.right_raw_cm);
            waited = it.now_ms - ctl.mark_time;
            hazard = (c < regs.front_block_cm) || (l < regs.side_block_cm)
                || (r < regs.side_block_cm);
            res = '0;
            case (ctl.mode)
                MODE_SCAN:
                begin
                    if (c < regs.crash_cm)
                        res = begin_reverse(it.now_ms);
                    else if (hazard)
                        res = begin_turn(l, r, it.now_ms);
                    else
                        res = drive_cmd(ACT_FORWARD, SPEED_DRIVE);
                end
                MODE_PIVOT:
                begin
                    if (waited >= {16'd0, regs.pivot_ms})
                    begin
                        if (hazard)
                        begin
                            res = begin_turn(l, r, it.now_ms);
                        end
                        else
                        begin
                            res = drive_cmd(ACT_STOP, SPEED_STOP);
                            ctl.mark_time = it.now_ms;
                            ctl.mode = MODE_BRIEF;
                        end
                    end
                end
                MODE_BRIEF:
                begin
                    if (waited >= {16'd0, regs.brief_stop_ms})
                    begin
                        res = drive_cmd(ACT_FORWARD, SPEED_DRIVE);
                        ctl.mark_time = it.now_ms;
                        ctl.mode = MODE_HOLD;
                    end
                end
                MODE_HOLD:
                begin
                    if (c < regs.crash_cm)
                        res = begin_reverse(it.now_ms);
                    else if (hazard)
                        res = begin_turn(l, r, it.now_ms);
                    else if (waited >= {16'd0, regs.hold_ms})
                        ctl.mode = MODE_SCAN;
                end
                MODE_BACK:
                begin
                    if (waited >= {16'd0, regs.back_ms})
                    begin
                        res = drive_cmd(ACT_STOP, SPEED_STOP);
                        ctl.mode = MODE_SCAN;
                    end
                end
                default:
                begin
                    ctl.mode = MODE_SCAN;
                end
            endcase
            res.mode = ctl.mode;
            return res;
        end
    endfunction

    function automatic logic [7:0] pick_cm(input bit near);
        begin
            if (near)
            begin
                return 8'($urandom_range(1, 40));
            end
            case ($urandom_range(0, 3))
                0: return 8'd0;
                1: return 8'($urandom_range(101, 255));
                default: return 8'($urandom_range(60, 100));
            endcase
        end
    endfunction

    function automatic in_item_t roll_reading();
        in_item_t    it;
        int unsigned k;
        bit          mixed;
        begin
            k = $urandom_range(0, 99);
            if (k < 70)
                clock_ms = clock_ms + $urandom_range(0, span_ms);
            else if (k < 90)
                clock_ms = clock_ms + $urandom_range(0, 4 * span_ms);
            else if (k < 97)
                clock_ms = clock_ms + $urandom_range(0, 70000);
            else
                clock_ms = $urandom();
            mixed = $urandom_range(0, 4) < 2;
            it.left_raw_cm = pick_cm(mixed && $urandom_range(0, 1));
            it.center_raw_cm = pick_cm(mixed && $urandom_range(0, 1));
            it.right_raw_cm = pick_cm(mixed && $urandom_range(0, 1));
            it.now_ms = clock_ms;
            return it;
        end
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        begin
            if (act_v !== exp_v)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                         exp_v, act_v);
                errors++;
            end
        end
    endtask

    task automatic store_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        begin
            case (idx)
                REG_FRONT_BLOCK: regs.front_block_cm = data[6:0];
                REG_SIDE_BLOCK:  regs.side_block_cm = data[6:0];
                REG_CRASH:       regs.crash_cm = data[6:0];
                REG_PIVOT:       regs.pivot_ms = data;
                REG_BRIEF_STOP:  regs.brief_stop_ms = data;
                REG_HOLD:        regs.hold_ms = data;
                REG_BACK:        regs.back_ms = data;
                default: ;
            endcase
        end
    endtask

    task automatic program_regs(input bit poke_unused);
        logic [CFG_DATA_W-1:0] junk;
        begin
            for (int k = 0; k < 7; k++)
            begin
                cfg_wr_en <= 1'b1;
                cfg_index <= REG_ORDER[k];
                cfg_data <= reg_plan[k];
                @(posedge clk);
                store_reg(REG_ORDER[k], reg_plan[k]);
            end
            if (poke_unused)
            begin
                junk = 16'($urandom());
                cfg_index <= REG_UNUSED;
                cfg_data <= junk;
                @(posedge clk);
                store_reg(REG_UNUSED, junk);
            end
            cfg_wr_en <= 1'b0;
            settings_used++;
        end
    endtask

    task automatic push_reading(input in_item_t item, input bit typed, input out_item_t want);
        out_item_t guess;
        begin
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_item <= item;
            do
                @(posedge clk);
            while (in_stall);
            guess = predict_drive(item);
            pending_drive.push_back(typed ? want : guess);
            readings_sent++;
        end
    endtask

    task automatic run_phase(input int count);
        begin
            for (int k = 0; k < count; k++)
            begin
                push_reading(roll_reading(), 1'b0, '0);
            end
        end
    endtask

    task automatic settle();
        begin
            in_valid <= 1'b0;
            while (pending_drive.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else if (!quiet && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 9);
        out_stall <= (stall_left > 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_drive.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
                errors++;
            end
            else
            begin
                head_drive = pending_drive.pop_front();
                check_field("drive_issued", 8'(head_drive.drive_issued),
                            8'(out_item.drive_issued));
                check_field("drive_action", 8'(head_drive.drive_action),
                            8'(out_item.drive_action));
                check_field("speed_percent", 8'(head_drive.speed_percent),
                            8'(out_item.speed_percent));
                check_field("mode", 8'(head_drive.mode), 8'(out_item.mode));
                results_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding", $time,
                     pending_drive.size());
            $display("ultrasonic_obstacle_avoid_fsm test failed");
            $finish;
        end
    end

    initial
    begin
        regs = '{FRONT_BLOCK_RESET, SIDE_BLOCK_RESET, CRASH_RESET, PIVOT_MS_RESET,
                 BRIEF_STOP_MS_RESET, HOLD_MS_RESET, BACK_MS_RESET};
        ctl = '{MODE_STOP, 32'd0, DIR_LEFT};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
            push_reading(dir_rows[k].reading, dir_rows[k].typed, dir_rows[k].want);
        run_phase(300);

        settle();
        reg_plan = '{16'($urandom_range(0, 100)), 16'($urandom_range(0, 100)),
                     16'($urandom_range(0, 100)), 16'($urandom_range(0, 300)),
                     16'($urandom_range(0, 300)), 16'($urandom_range(0, 400)),
                     16'($urandom_range(0, 600))};
        program_regs(1'b0);
        span_ms = 150;
        run_phase(350);

        settle();
        reg_plan = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        program_regs(1'b1);
        span_ms = 3;
        clock_ms = $urandom();
        run_phase(250);

        settle();
        reg_plan = '{16'd100, 16'd100, 16'd100, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        program_regs(1'b0);
        span_ms = 20000;
        clock_ms = 32'hFFF0_0000;
        run_phase(200);

        settle();
        reg_plan = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        program_regs(1'b1);
        run_phase(150);

        settle();
        reg_plan = '{{9'($urandom()), 7'($urandom_range(0, 100))},
                     {9'($urandom()), 7'($urandom_range(0, 40))},
                     {9'($urandom()), 7'($urandom_range(0, 40))},
                     16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                     16'($urandom_range(0, 200)), 16'($urandom_range(0, 200))};
        program_regs(1'b1);
        span_ms = 80;
        run_phase(250);

        settle();
        reg_plan = '{16'd30, 16'd10, 16'd10, 16'd80, 16'd80, 16'd100, 16'd250};
        program_regs(1'b0);
        span_ms = 60;
        quiet = 1'b1;
        run_phase(300);

        settle();
        repeat (8) @(posedge clk);
        $display("Drove %0d sensor readings under %0d register settings, including zero,",
                 readings_sent, settings_used);
        $display("maximum and wrapped-time cases; %0d drive results compared.", results_seen);
        if (errors == 0)
        begin
            $display("ultrasonic_obstacle_avoid_fsm test passed");
        end
        else
        begin
            $display("ultrasonic_obstacle_avoid_fsm test failed");
        end
        $finish;
    end

endmodule
